@@ hdl/atfs_pkg.sv @@
// Shared types and codes for the animation tick-to-frame sequencer.
package atfs_pkg;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_STEP   = 2'd2;
   localparam logic [1:0] MODE_REWIND = 2'd3;

   localparam logic REG_FRAME_TOTAL = 1'b0;
   localparam logic REG_LOOP_ENABLE = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [5:0]         frame_slot;
      logic [15:0]        frame_duration;
      logic [31:0]        sample_tick;
      logic               sample_present;
      logic [31:0]        query_tick;
      logic signed [15:0] step_delta;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [5:0]  frame_sel;
      logic [31:0] src_tick_out;
      logic        source_found;
      logic [31:0] play_tick;
   } rsp_type;

   typedef struct packed {
      logic [31:0] first_tick;
      logic [31:0] src_tick;
      logic        source_valid;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } mod_req_type;

endpackage

@@ hdl/animation_tick_to_frame_sequencer_top.sv @@
// Top level of the animation tick-to-frame sequencer: control sequencer and clip state.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_data  (req_type)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data  (rsp_type)
//  csr     | in        | csr_we              | csr_index, csr_wdata
//
// A new request is taken only when the sequencer is idle. Loads and empty clips skip
// the linear start-tick scan; a query or step also runs the serial remainder unit when
// the clip length is nonzero, and a looping step runs it again for the frame wrap.
// Reset is synchronous; tables are not cleared. A stalled result stays in the output
// register; one more request is computed behind it and then req_stall stays high.
module animation_tick_to_frame_sequencer_top import atfs_pkg::*; #(
   parameter int MAX_FRAMES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_FRAMES);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W = ((IDX_W > 16) ? IDX_W : 16) + 2;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_MOD_WAIT  = 3'd1;
   localparam logic [2:0] S_SCAN      = 3'd2;
   localparam logic [2:0] S_STEP      = 3'd3;
   localparam logic [2:0] S_LOOP_WAIT = 3'd4;
   localparam logic [2:0] S_FETCH     = 3'd5;
   localparam logic [2:0] S_WAIT      = 3'd6;
   localparam logic [2:0] S_OUT       = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [6:0]         frame_total_ff, frame_total_in;
   logic               loop_enable_ff, loop_enable_in;
   logic [31:0]        clip_dur_ff, clip_dur_in;
   logic [31:0]        cur_tick_ff, cur_tick_in;
   logic [1:0]         mode_ff, mode_in;
   logic signed [15:0] delta_ff, delta_in;
   logic [31:0]        wtick_ff, wtick_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]   sel_ff, sel_in;
   logic               neg_ff, neg_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]         frame_cnt;
   logic                     req_accept;
   logic                     rsp_take;
   logic                     slot_ok;
   logic [31:0]              load_start;
   logic                     wr_en;
   logic [IDX_W-1:0]         rd_addr;
   entry_type                wr_entry;
   entry_type                rd_entry;
   logic [$bits(entry_type)-1:0] rd_bits;
   mod_req_type              mod_req;
   logic                     mod_done;
   logic [31:0]              mod_rem;
   logic [CNT_W-1:0]         rem_c;
   logic signed [SUM_W-1:0]  step_sum;
   logic                     step_neg;
   logic [SUM_W-1:0]         step_mag;

   assign frame_cnt  = (32'(frame_total_ff) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                               : CNT_W'(frame_total_ff);
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_take   = rsp_valid_ff & ~rsp_stall;
   assign slot_ok    = (32'(req_data.frame_slot) < 32'(MAX_FRAMES));
   assign load_start = (req_data.frame_slot == 6'd0) ? 32'd0 : clip_dur_ff;

   assign wr_en                 = req_accept && (req_data.mode == MODE_LOAD) && slot_ok;
   assign wr_entry.first_tick   = load_start;
   assign wr_entry.src_tick     = req_data.sample_tick;
   assign wr_entry.source_valid = req_data.sample_present;
   assign rd_addr               = (state_ff == S_SCAN) ? scan_ff[IDX_W-1:0] : sel_ff;
   assign rd_entry              = entry_type'(rd_bits);

   assign step_sum = $signed({{(SUM_W - IDX_W){1'b0}}, sel_ff}) + SUM_W'(delta_ff);
   assign step_neg = step_sum[SUM_W-1];
   assign step_mag = step_neg ? SUM_W'(-step_sum) : SUM_W'(step_sum);
   assign rem_c    = mod_rem[CNT_W-1:0];

   atfs_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_data.frame_slot)),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   atfs_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .done    (mod_done),
      .rem     (mod_rem)
   );

   always_comb begin
      frame_total_in = frame_total_ff;
      loop_enable_in = loop_enable_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_TOTAL: frame_total_in = csr_wdata;
            REG_LOOP_ENABLE: loop_enable_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      clip_dur_in      = clip_dur_ff;
      cur_tick_in      = cur_tick_ff;
      mode_in          = mode_ff;
      delta_in         = delta_ff;
      wtick_in         = wtick_ff;
      scan_in          = scan_ff;
      pend_in          = pend_ff;
      pend_idx_in      = pend_idx_ff;
      sel_in           = sel_ff;
      neg_in           = neg_ff;
      res_in           = res_ff;
      rsp_valid_in     = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      mod_req.start    = 1'b0;
      mod_req.dividend = wtick_in;
      mod_req.divisor  = clip_dur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_in   = req_data.mode;
               delta_in  = req_data.step_delta;
               scan_in   = '0;
               pend_in   = 1'b0;
               sel_in    = '0;
               res_in    = '0;
               res_in.play_tick = cur_tick_ff;
               state_in  = S_OUT;
               if (req_data.mode == MODE_LOAD) begin
                  if (slot_ok) begin
                     clip_dur_in         = load_start + 32'(req_data.frame_duration);
                     res_in.ok           = 1'b1;
                     res_in.frame_sel    = req_data.frame_slot;
                     res_in.src_tick_out = req_data.sample_present ?
                                           req_data.sample_tick : 32'd0;
                     res_in.source_found = req_data.sample_present;
                  end
               end else begin
                  if (req_data.mode == MODE_REWIND) begin
                     cur_tick_in      = '0;
                     res_in.play_tick = '0;
                     wtick_in         = '0;
                  end else if (req_data.mode == MODE_QUERY) begin
                     wtick_in = req_data.query_tick;
                  end else begin
                     wtick_in = cur_tick_ff;
                  end
                  if (frame_cnt != '0) begin
                     if ((req_data.mode != MODE_REWIND) && (clip_dur_ff != '0)) begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = wtick_in;
                        state_in         = S_MOD_WAIT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               end
            end
         end
         S_MOD_WAIT: begin
            if (mod_done) begin
               wtick_in = mod_rem;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_ff < frame_cnt) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (rd_entry.first_tick <= wtick_ff)) begin
               sel_in = pend_idx_ff;
            end
            if ((scan_ff == frame_cnt) && !pend_ff) begin
               state_in = (mode_ff == MODE_STEP) ? S_STEP : S_FETCH;
            end
         end
         S_STEP: begin
            neg_in = step_neg;
            if (loop_enable_ff) begin
               mod_req.start    = 1'b1;
               mod_req.dividend = 32'(step_mag);
               mod_req.divisor  = 32'(frame_cnt);
               state_in         = S_LOOP_WAIT;
            end else begin
               if (step_neg) begin
                  sel_in = '0;
               end else if (32'(step_mag) >= 32'(frame_cnt)) begin
                  sel_in = IDX_W'(frame_cnt - CNT_W'(1));
               end else begin
                  sel_in = IDX_W'(step_mag);
               end
               state_in = S_FETCH;
            end
         end
         S_LOOP_WAIT: begin
            if (mod_done) begin
               if (neg_ff && (rem_c != '0)) begin
                  sel_in = IDX_W'(frame_cnt - rem_c);
               end else begin
                  sel_in = IDX_W'(rem_c);
               end
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            res_in.ok           = 1'b1;
            res_in.frame_sel    = 6'(sel_ff);
            res_in.src_tick_out = rd_entry.source_valid ? rd_entry.src_tick : 32'd0;
            res_in.source_found = rd_entry.source_valid;
            res_in.play_tick    = cur_tick_ff;
            if (mode_ff == MODE_STEP) begin
               cur_tick_in      = rd_entry.first_tick;
               res_in.play_tick = rd_entry.first_tick;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         frame_total_ff <= '0;
         loop_enable_ff <= 1'b0;
         clip_dur_ff    <= '0;
         cur_tick_ff    <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_total_ff <= frame_total_in;
         loop_enable_ff <= loop_enable_in;
         clip_dur_ff    <= clip_dur_in;
         cur_tick_ff    <= cur_tick_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      delta_ff    <= delta_in;
      wtick_ff    <= wtick_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      sel_ff      <= sel_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/atfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module atfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/atfs_mod.sv @@
// Serial 32-bit remainder unit, one quotient bit per cycle.
module atfs_mod import atfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output logic        done,
   output logic [31:0] rem
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] div_ff, div_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[31]};
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = mod_req.dividend;
         div_in  = mod_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 32'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[31:0];
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

@@ verif/animation_tick_to_frame_sequencer_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the animation tick-to-frame sequencer top level.
module animation_tick_to_frame_sequencer_top_test;
   import atfs_pkg::*;

   localparam int MAX_FRAMES   = 64;
   localparam int TARGET_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_we;
   logic       csr_index;
   logic [6:0] csr_wdata;

   animation_tick_to_frame_sequencer_top #(.MAX_FRAMES(MAX_FRAMES)) DUT (.*);

   always #2 clock = ~clock;

   // sequencer copy: clip tables, running sum, playback tick, settings
   logic [31:0] first_ticks [MAX_FRAMES];
   logic [31:0] src_ticks   [MAX_FRAMES];
   logic        source_flags [MAX_FRAMES];
   logic [31:0] clip_length;
   logic [31:0] play_position;
   logic [6:0]  total_setting;
   logic        loop_setting;

   rsp_type     frame_expected [$];
   req_type     pending_items [$];
   logic [31:0] plan_sum;
   int          planned;
   int          errors;
   int          req_transfers;
   int          rsp_transfers;
   int          phases;
   int          send_gap;
   int          stall_left;
   int          hold_left;
   int          holds_done;
   bit          idle_on;

   function automatic int active_frames();
      return (total_setting > MAX_FRAMES) ? MAX_FRAMES : int'(total_setting);
   endfunction

   function automatic int select_frame(logic [31:0] tick);
      logic [31:0] wrapped;
      int          sel;
      wrapped = (clip_length != 0) ? tick % clip_length : tick;
      sel = 0;
      for (int i = 0; i < active_frames(); i++)
         if (first_ticks[i] <= wrapped) sel = i;
      return sel;
   endfunction

   function automatic rsp_type frame_report(bit found, int idx);
      rsp_type r;
      r = '0;
      if (found) begin
         r.ok           = 1'b1;
         r.frame_sel    = idx[5:0];
         r.source_found = source_flags[idx];
         r.src_tick_out = source_flags[idx] ? src_ticks[idx] : 32'd0;
      end
      r.play_tick = play_position;
      return r;
   endfunction

   function automatic void expect_rsp(rsp_type r);
      frame_expected.insert(frame_expected.size(), r);
   endfunction

   task automatic predict_frame(req_type item);
      int count;
      int idx;
      int delta;
      count = active_frames();
      case (item.mode)
         MODE_LOAD: begin
            if (item.frame_slot >= MAX_FRAMES) begin
               expect_rsp(frame_report(1'b0, 0));
            end else begin
               if (item.frame_slot == 0) clip_length = '0;
               first_ticks[item.frame_slot]  = clip_length;
               clip_length                   = clip_length + 32'(item.frame_duration);
               src_ticks[item.frame_slot]    = item.sample_tick;
               source_flags[item.frame_slot] = item.sample_present;
               expect_rsp(frame_report(1'b1, int'(item.frame_slot)));
            end
         end
         MODE_QUERY: begin
            if (count == 0) expect_rsp(frame_report(1'b0, 0));
            else expect_rsp(frame_report(1'b1, select_frame(item.query_tick)));
         end
         MODE_STEP: begin
            if (count == 0) begin
               expect_rsp(frame_report(1'b0, 0));
            end else begin
               delta = {{16{item.step_delta[15]}}, item.step_delta};
               idx = select_frame(play_position) + delta;
               if (loop_setting) begin
                  idx = idx % count;
                  if (idx < 0) idx += count;
               end else begin
                  if (idx < 0) idx = 0;
                  if (idx > count - 1) idx = count - 1;
               end
               play_position = first_ticks[idx];
               expect_rsp(frame_report(1'b1, idx));
            end
         end
         default: begin
            play_position = '0;
            if (count == 0) expect_rsp(frame_report(1'b0, 0));
            else expect_rsp(frame_report(1'b1, select_frame(32'd0)));
         end
      endcase
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   function automatic int pause_length();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: predicts each request transfer, then offers the next pending item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_frame(req_data);
            req_transfers++;
            send_gap = pause_length();
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with two long hold-offs to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done < 2 && req_transfers >= 150 + holds_done * 500) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pause_length();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_transfers++;
         if (frame_expected.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected response, expected none, actual %h", $time, rsp_data);
         end else begin
            want = frame_expected.pop_front();
            check_field("ok", 32'(want.ok), 32'(rsp_data.ok));
            check_field("frame_sel", 32'(want.frame_sel), 32'(rsp_data.frame_sel));
            check_field("src_tick_out", want.src_tick_out, rsp_data.src_tick_out);
            check_field("source_found", 32'(want.source_found), 32'(rsp_data.source_found));
            check_field("play_tick", want.play_tick, rsp_data.play_tick);
         end
      end
   end

   function automatic req_type random_req(logic [1:0] mode);
      req_type r;
      r.mode           = mode;
      r.frame_slot     = 6'($urandom);
      r.frame_duration = 16'($urandom);
      r.sample_tick    = $urandom;
      r.sample_present = 1'($urandom);
      r.query_tick     = $urandom;
      r.step_delta     = 16'($urandom);
      return r;
   endfunction

   task automatic plan_item(req_type r);
      if (r.mode == MODE_LOAD) begin
         if (r.frame_slot == 0) plan_sum = '0;
         plan_sum += 32'(r.frame_duration);
      end
      pending_items.insert(pending_items.size(), r);
      planned++;
   endtask

   task automatic plan_fixed(logic [1:0] mode, logic [5:0] slot, logic [15:0] dur,
                             logic [31:0] tick, logic [15:0] delta);
      req_type r;
      r = random_req(mode);
      r.frame_slot     = slot;
      r.frame_duration = dur;
      r.query_tick     = tick;
      r.step_delta     = delta;
      plan_item(r);
   endtask

   function automatic logic [15:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 15) return 16'hFFFF;
      if (r < 80) return 16'($urandom_range(1, 20));
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_tick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'd0;
      if (r < 15) return 32'hFFFF_FFFF;
      if (r < 75) return $urandom_range(0, plan_sum * 2 + 2);
      return $urandom;
   endfunction

   function automatic logic [15:0] pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 16'($urandom_range(0, 6) - 3);
      if (r < 70) return 16'h8000;
      if (r < 80) return 16'h7FFF;
      if (r < 90) return 16'($urandom_range(0, 140) - 70);
      return 16'($urandom);
   endfunction

   task automatic load_clip(int count);
      req_type r;
      for (int s = 0; s < count; s++) begin
         r = random_req(MODE_LOAD);
         r.frame_slot     = 6'(s);
         r.frame_duration = pick_duration();
         plan_item(r);
      end
   endtask

   task automatic plan_op(logic [1:0] mode);
      req_type r;
      r = random_req(mode);
      r.query_tick = pick_tick();
      r.step_delta = pick_delta();
      plan_item(r);
   endtask

   task automatic write_reg(logic index, logic [6:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_FRAME_TOTAL) total_setting = value;
      else loop_setting = value[0];
   endtask

   task automatic wait_idle();
      while (req_transfers != planned || frame_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int count;
      int pick;
      req_type r;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = REG_FRAME_TOTAL;
      csr_wdata     = '0;
      clip_length   = '0;
      play_position = '0;
      total_setting = '0;
      loop_setting  = 1'b0;
      plan_sum      = '0;
      planned       = 0;
      errors        = 0;
      req_transfers = 0;
      rsp_transfers = 0;
      phases        = 0;
      holds_done    = 0;
      idle_on       = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty clip
      write_reg(REG_FRAME_TOTAL, 7'd0);
      write_reg(REG_LOOP_ENABLE, 7'd0);
      plan_fixed(MODE_QUERY, 6'd0, 16'd0, 32'hFFFF_FFFF, 16'd0);
      plan_fixed(MODE_STEP, 6'd0, 16'd0, 32'd0, 16'd1);
      plan_fixed(MODE_REWIND, 6'd0, 16'd0, 32'd0, 16'd0);
      wait_idle();

      // four frames, zero-length first frame, clamped steps
      write_reg(REG_FRAME_TOTAL, 7'd4);
      plan_fixed(MODE_LOAD, 6'd0, 16'd0, 32'd0, 16'd0);
      plan_fixed(MODE_LOAD, 6'd1, 16'hFFFF, 32'd0, 16'd0);
      plan_fixed(MODE_LOAD, 6'd2, 16'd1, 32'd0, 16'd0);
      plan_fixed(MODE_LOAD, 6'd3, 16'd5, 32'd0, 16'd0);
      plan_fixed(MODE_QUERY, 6'd0, 16'd0, 32'd0, 16'd0);
      plan_fixed(MODE_QUERY, 6'd0, 16'd0, 32'hFFFF_FFFF, 16'd0);
      plan_fixed(MODE_QUERY, 6'd0, 16'd0, 32'd65540, 16'd0);
      plan_fixed(MODE_STEP, 6'd0, 16'd0, 32'd0, 16'd1);
      plan_fixed(MODE_STEP, 6'd0, 16'd0, 32'd0, 16'h7FFF);
      plan_fixed(MODE_STEP, 6'd0, 16'd0, 32'd0, 16'h8000);
      plan_fixed(MODE_REWIND, 6'd0, 16'd0, 32'd0, 16'd0);
      wait_idle();

      // same clip, wrapping steps
      write_reg(REG_LOOP_ENABLE, 7'd1);
      plan_fixed(MODE_STEP, 6'd0, 16'd0, 32'd0, 16'hFFFF);
      plan_fixed(MODE_STEP, 6'd0, 16'd0, 32'd0, 16'h7FFF);
      plan_fixed(MODE_STEP, 6'd0, 16'd0, 32'd0, 16'h8000);
      wait_idle();

      // zero total duration: query tick is not wrapped
      write_reg(REG_FRAME_TOTAL, 7'd2);
      write_reg(REG_LOOP_ENABLE, 7'd0);
      plan_fixed(MODE_LOAD, 6'd0, 16'd0, 32'd0, 16'd0);
      plan_fixed(MODE_LOAD, 6'd1, 16'd0, 32'd0, 16'd0);
      plan_fixed(MODE_QUERY, 6'd0, 16'd0, 32'd7, 16'd0);
      plan_fixed(MODE_STEP, 6'd0, 16'd0, 32'd0, 16'd1);

      while (planned < TARGET_ITEMS) begin
         wait_idle();
         pick = $urandom_range(0, 9);
         if (phases == 0 || pick == 1) count = MAX_FRAMES;
         else if (pick == 0) count = 0;
         else if (pick < 8) count = $urandom_range(1, 8);
         else count = $urandom_range(9, MAX_FRAMES - 1);
         write_reg(REG_FRAME_TOTAL, 7'(count));
         write_reg(REG_LOOP_ENABLE, 7'($urandom_range(0, 1)));
         idle_on <= ($urandom_range(0, 3) != 0);
         phases++;
         load_clip(count);
         repeat ($urandom_range(20, 60)) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               plan_op(MODE_QUERY);
            end else if (pick < 72) begin
               plan_op(MODE_STEP);
            end else if (pick < 82) begin
               plan_op(MODE_REWIND);
            end else if (pick < 92 || count == 0) begin
               r = random_req(2'($urandom));
               plan_item(r);
            end else begin
               load_clip($urandom_range(1, count));
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_expected.size() != 0) begin
         errors += frame_expected.size();
         $display("%0t ns: %0d responses missing, expected %h, actual none",
                  $time, frame_expected.size(), frame_expected[0]);
      end
      $display("Checked %0d responses for %0d requests over %0d random clip settings,",
               rsp_transfers, req_transfers, phases);
      $display("with empty, clamped and looping clips, reloads, long receiver hold-offs.");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
